// ===== rtl/hsc_pkg.sv =====
// Shared types, constants and elaboration-time helpers of the Hamming SEC core.
`timescale 1ns / 1ps
package hsc_pkg;

	localparam int MAX_PARITY = 6;
	localparam int CW_W = 63;
	localparam int LEN_W = 6;
	localparam int MAX_DATA = (2 ** MAX_PARITY) - 1 - MAX_PARITY;
	localparam int RESET_DATA_LENGTH = 4;

	// APB register map
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_DATA_LENGTH = 1'b0;

	// Operation codes
	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// Status codes
	localparam logic [1:0] STATUS_OK            = 2'd0;
	localparam logic [1:0] STATUS_CORRECTED     = 2'd1;
	localparam logic [1:0] STATUS_UNCORRECTABLE = 2'd2;

	typedef struct packed {
		logic            operation;
		logic [CW_W-1:0] payload;
	} req_t;

	typedef struct packed {
		logic [CW_W-1:0]  code_word;
		logic [LEN_W-1:0] code_length;
		logic [LEN_W-1:0] syndrome;
		logic [1:0]       status;
	} rsp_t;

	// Settings derived from data_length, held in registers
	typedef struct packed {
		logic [LEN_W-1:0] code_length;
		logic [CW_W-1:0]  data_mask;
		logic [CW_W-1:0]  code_mask;
	} cfg_t;

	// Word after data placement or masking
	typedef struct packed {
		logic            operation;
		logic [CW_W-1:0] word;
	} s1_t;

	// Word with its syndrome
	typedef struct packed {
		logic             operation;
		logic [CW_W-1:0]  word;
		logic [LEN_W-1:0] syndrome;
	} s2_t;

	// Clamp a data length into 1 .. MAX_DATA
	function automatic logic [LEN_W-1:0] eff_data_length(input logic [LEN_W-1:0] d);
		logic [LEN_W-1:0] r;
		r = d;
		if (d == '0)
			r = LEN_W'(1);
		else if (d > LEN_W'(MAX_DATA))
			r = LEN_W'(MAX_DATA);
		return r;
	endfunction

	// Code length for an effective data length: data bits plus fewest parity bits
	function automatic logic [LEN_W-1:0] code_len_for(input logic [LEN_W-1:0] d);
		logic [LEN_W-1:0] n;
		n = LEN_W'(int'(d) + MAX_PARITY);
		for (int k = MAX_PARITY; k >= 1; k--) begin
			if (((2 ** k) - k - 1) >= int'(d))
				n = LEN_W'(int'(d) + k);
		end
		return n;
	endfunction

	// True for positions that hold a parity bit
	function automatic bit is_parity_pos(input int p);
		return (p > 0) && ((p & (p - 1)) == 0) && (p <= (1 << (MAX_PARITY - 1)));
	endfunction

	// Data bit index held at a non-parity position
	function automatic int data_index(input int p);
		int cnt;
		cnt = 0;
		for (int j = 0; j < MAX_PARITY; j++) begin
			if ((1 << j) <= p)
				cnt++;
		end
		return p - 1 - cnt;
	endfunction

	// Positions whose number has bit k set
	function automatic logic [CW_W-1:0] pos_mask(input int k);
		logic [CW_W-1:0] m;
		m = '0;
		for (int p = 1; p <= CW_W; p++)
			m[p-1] = ((p >> k) & 1) != 0;
		return m;
	endfunction

endpackage

// ===== rtl/hsc_apb_regs.sv =====
// APB configuration register for the data length and its derived settings.
`timescale 1ns / 1ps
module hsc_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hsc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [hsc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [hsc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output hsc_pkg::cfg_t                  cfg
);
	import hsc_pkg::*;

	logic [LEN_W-1:0] data_length_q;
	cfg_t             cfg_q;
	logic [LEN_W-1:0] wr_len;
	logic [LEN_W-1:0] wr_eff;
	logic [LEN_W-1:0] wr_n;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DATA_LENGTH);

	// Derive code length and masks for the value being written
	assign wr_len = pwdata[LEN_W-1:0];
	assign wr_eff = eff_data_length(wr_len);
	assign wr_n   = code_len_for(wr_eff);

	// Hold the register and its derived settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_length_q     <= LEN_W'(RESET_DATA_LENGTH);
			cfg_q.code_length <= code_len_for(eff_data_length(LEN_W'(RESET_DATA_LENGTH)));
			cfg_q.data_mask   <= ~({CW_W{1'b1}} << RESET_DATA_LENGTH);
			cfg_q.code_mask   <= ~({CW_W{1'b1}}
				<< code_len_for(eff_data_length(LEN_W'(RESET_DATA_LENGTH))));
		end else if (wr_en) begin
			data_length_q     <= wr_len;
			cfg_q.code_length <= wr_n;
			cfg_q.data_mask   <= ~({CW_W{1'b1}} << wr_eff);
			cfg_q.code_mask   <= ~({CW_W{1'b1}} << wr_n);
		end
	end

	// Return the register on a read of its address
	always_comb begin
		prdata = '0;
		if (psel && !pwrite && (paddr[2] == REG_DATA_LENGTH))
			prdata = APB_DATA_W'(data_length_q);
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/hsc_place_stage.sv =====
// First stage: place data bits around parity slots, or mask a received word.
`timescale 1ns / 1ps
module hsc_place_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  hsc_pkg::cfg_t cfg,
	input  logic          up_valid,
	output logic          up_ready,
	input  hsc_pkg::req_t up_data,
	output logic          down_valid,
	input  logic          down_ready,
	output hsc_pkg::s1_t  down_data
);
	import hsc_pkg::*;

	logic            valid_s1;
	s1_t             data_s1;
	logic [CW_W-1:0] data_m;
	logic [CW_W-1:0] enc_word;

	assign data_m = up_data.payload & cfg.data_mask;

	// Scatter data bits over the non-parity positions
	for (genvar p = 1; p <= CW_W; p++) begin : g_place
		if (is_parity_pos(p)) begin : g_par
			assign enc_word[p-1] = 1'b0;
		end else begin : g_dat
			assign enc_word[p-1] = data_m[data_index(p)];
		end
	end

	assign up_ready = !valid_s1 || down_ready;

	// Advance when the next stage has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (up_ready)
			valid_s1 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1.operation <= up_data.operation;
			data_s1.word      <= (up_data.operation == OP_DECODE)
				? (up_data.payload & cfg.code_mask) : enc_word;
		end
	end

	assign down_valid = valid_s1;
	assign down_data  = data_s1;

endmodule

// ===== rtl/hsc_syndrome_stage.sv =====
// Second stage: XOR trees giving the position-weighted syndrome of the word.
`timescale 1ns / 1ps
module hsc_syndrome_stage (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         up_valid,
	output logic         up_ready,
	input  hsc_pkg::s1_t up_data,
	output logic         down_valid,
	input  logic         down_ready,
	output hsc_pkg::s2_t down_data
);
	import hsc_pkg::*;

	logic             valid_s2;
	s2_t              data_s2;
	logic [LEN_W-1:0] syn;

	// One parity tree per syndrome bit
	for (genvar k = 0; k < LEN_W; k++) begin : g_syn
		assign syn[k] = ^(up_data.word & pos_mask(k));
	end

	assign up_ready = !valid_s2 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (up_ready)
			valid_s2 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2.operation <= up_data.operation;
			data_s2.word      <= up_data.word;
			data_s2.syndrome  <= syn;
		end
	end

	assign down_valid = valid_s2;
	assign down_data  = data_s2;

endmodule

// ===== rtl/hsc_finish_stage.sv =====
// Third stage: insert parity bits, or correct the named bit or flag it as uncorrectable, into the output register.
`timescale 1ns / 1ps
module hsc_finish_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  hsc_pkg::cfg_t cfg,
	input  logic          up_valid,
	output logic          up_ready,
	input  hsc_pkg::s2_t  up_data,
	output logic          down_valid,
	input  logic          down_ready,
	output hsc_pkg::rsp_t down_data
);
	import hsc_pkg::*;

	logic             valid_s3;
	rsp_t             data_s3;
	rsp_t             res;
	logic [CW_W-1:0]  enc_word;
	logic [LEN_W-1:0] flip_idx;

	// Drop each syndrome bit into its parity slot
	always_comb begin
		enc_word = up_data.word;
		for (int k = 0; k < MAX_PARITY; k++)
			enc_word[(1 << k) - 1] = up_data.syndrome[k];
	end

	assign flip_idx = up_data.syndrome - LEN_W'(1);

	// Build the transaction result
	always_comb begin
		res.code_length = cfg.code_length;
		res.code_word   = up_data.word;
		res.syndrome    = '0;
		res.status      = STATUS_OK;
		if (up_data.operation == OP_ENCODE) begin
			res.code_word = enc_word;
		end else begin
			res.syndrome = up_data.syndrome;
			if (up_data.syndrome == '0) begin
				res.status = STATUS_OK;
			end else if (up_data.syndrome <= cfg.code_length) begin
				res.code_word = up_data.word ^ (CW_W'(1) << flip_idx);
				res.status    = STATUS_CORRECTED;
			end else begin
				res.status = STATUS_UNCORRECTABLE;
			end
		end
	end

	assign up_ready = !valid_s3 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (up_ready)
			valid_s3 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid)
			data_s3 <= res;
	end

	assign down_valid = valid_s3;
	assign down_data  = data_s3;

endmodule

// ===== rtl/hamming_sec_encode_decode_core.sv =====
// Top level of the variable-length Hamming SEC encoder and corrector.
// An accepted transaction passes the place, syndrome and finish stage registers to rsp.
// Throughput: one transaction per cycle; each stage is one register with its
// own valid bit, so a stall on rsp backs up through the three stages.
// Reset (arst_n low) empties the pipeline and sets data_length to 4.
`timescale 1ns / 1ps
module hamming_sec_encode_decode_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hsc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [hsc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [hsc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  hsc_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output hsc_pkg::rsp_t                  rsp
);
	import hsc_pkg::*;

	cfg_t cfg;
	logic v1;
	logic r1;
	s1_t  d1;
	logic v2;
	logic r2;
	s2_t  d2;

	hsc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hsc_place_stage u_place (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.up_valid   (req_valid),
		.up_ready   (req_ready),
		.up_data    (req),
		.down_valid (v1),
		.down_ready (r1),
		.down_data  (d1)
	);

	hsc_syndrome_stage u_syn (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (v1),
		.up_ready   (r1),
		.up_data    (d1),
		.down_valid (v2),
		.down_ready (r2),
		.down_data  (d2)
	);

	hsc_finish_stage u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.up_valid   (v2),
		.up_ready   (r2),
		.up_data    (d2),
		.down_valid (rsp_valid),
		.down_ready (rsp_ready),
		.down_data  (rsp)
	);

endmodule

// ===== dv/hamming_sec_checker.sv =====
// Checker for the Hamming SEC core: tracks data_length, predicts every result and compares.
`timescale 1ns / 1ps
module hamming_sec_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hsc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [hsc_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [hsc_pkg::APB_DATA_W-1:0] prdata,
	input  logic                           pready,
	input  logic                           req_valid,
	input  logic                           req_ready,
	input  hsc_pkg::req_t                  req,
	input  logic                           rsp_valid,
	input  logic                           rsp_ready,
	input  hsc_pkg::rsp_t                  rsp,
	output int                             errors,
	output int                             pending
);
	import hsc_pkg::*;

	localparam logic [APB_ADDR_W-1:0] DL_ADDR = APB_ADDR_W'(4 * int'(REG_DATA_LENGTH));

	logic [LEN_W-1:0] data_len;
	rsp_t             codeword_queue[$];
	rsp_t             want;
	int               fail_count = 0;
	int               outstanding = 0;

	assign errors  = fail_count;
	assign pending = outstanding;

	// Print one line per mismatch and count it
	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_val);
		$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
		fail_count++;
	endtask

	// Work out the result of one transaction for the given data_length setting
	function automatic rsp_t hamming_predict(input req_t item, input logic [LEN_W-1:0] len_reg);
		int          d;
		int          n;
		int          p;
		int          syn;
		logic [63:0] nmask;
		logic [63:0] word;
		rsp_t        r;
		d = int'(len_reg);
		if (d < 1)
			d = 1;
		if (d > MAX_DATA)
			d = MAX_DATA;
		// Place the data bits, skipping parity positions
		word = '0;
		p = 0;
		for (int i = 0; i < d; i++) begin
			p++;
			while ((p & (p - 1)) == 0 && p <= (1 << (MAX_PARITY - 1)))
				p++;
			if (item.operation == OP_ENCODE && item.payload[i])
				word[p-1] = 1'b1;
		end
		n = p;
		nmask = (64'd1 << n) - 64'd1;
		if (item.operation == OP_DECODE)
			word = {1'b0, item.payload} & nmask;
		syn = 0;
		for (int q = 1; q <= n; q++) begin
			if (word[q-1])
				syn ^= q;
		end
		r = '0;
		r.code_length = LEN_W'(n);
		if (item.operation == OP_ENCODE) begin
			// With parity bits still clear, the syndrome spells out each parity value
			for (int k = 0; k < MAX_PARITY; k++) begin
				if ((1 << k) <= n && ((syn >> k) & 1) != 0)
					word[(1 << k) - 1] = 1'b1;
			end
		end else begin
			r.syndrome = LEN_W'(syn);
			if (syn == 0) begin
				r.status = STATUS_OK;
			end else if (syn <= n) begin
				word[syn-1] = ~word[syn-1];
				r.status = STATUS_CORRECTED;
			end else begin
				r.status = STATUS_UNCORRECTABLE;
			end
		end
		r.code_word = word[CW_W-1:0] & nmask[CW_W-1:0];
		return r;
	endfunction

	// Track the register, queue predictions, check results and read-backs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_len <= LEN_W'(RESET_DATA_LENGTH);
		end else begin
			if (psel && penable && pready && paddr == DL_ADDR) begin
				if (pwrite)
					data_len <= pwdata[LEN_W-1:0];
				else if (prdata !== APB_DATA_W'(data_len))
					report("data_length read-back", 64'(prdata), 64'(data_len));
			end
			if (req_valid && req_ready)
				codeword_queue.push_back(hamming_predict(req, data_len));
			if (rsp_valid && rsp_ready) begin
				if (codeword_queue.size() == 0) begin
					report("unexpected result", 64'(rsp), 64'd0);
				end else begin
					want = codeword_queue.pop_front();
					if (rsp.code_word !== want.code_word)
						report("code_word", 64'(rsp.code_word), 64'(want.code_word));
					if (rsp.code_length !== want.code_length)
						report("code_length", 64'(rsp.code_length), 64'(want.code_length));
					if (rsp.syndrome !== want.syndrome)
						report("syndrome", 64'(rsp.syndrome), 64'(want.syndrome));
					if (rsp.status !== want.status)
						report("status", 64'(rsp.status), 64'(want.status));
				end
			end
			outstanding = codeword_queue.size();
		end
	end

endmodule

// ===== dv/hamming_sec_encode_decode_core_tb.sv =====
// Testbench top for the Hamming SEC core: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module hamming_sec_encode_decode_core_tb;
	import hsc_pkg::*;

	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 60;
	localparam int TAIL_CYCLES  = 10;
	localparam logic [APB_ADDR_W-1:0] DL_ADDR = APB_ADDR_W'(4 * int'(REG_DATA_LENGTH));
	localparam logic [CW_W-1:0]       ALL_ONES = {CW_W{1'b1}};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;

	int snd_idle = 0;
	int rcv_idle = 0;
	bit hold_pending = 1'b0;
	int cycles = 0;
	int errors;
	int pending;

	hamming_sec_encode_decode_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	hamming_sec_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("hamming_sec_encode_decode_core_tb: errors");
			$finish;
		end
	end

	// Result side: random back-pressure, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// Offer one transaction after a random gap and hold it until accepted
	task automatic send_word(input logic op, input logic [CW_W-1:0] data);
		while ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid     <= 1'b1;
		req.operation <= op;
		req.payload   <= data;
		do @(posedge clk); while (!req_ready);
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// One APB setup and access phase on the data_length register
	task automatic apb_access(input logic wr, input logic [LEN_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= DL_ADDR;
		if (wr)
			pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// Change data_length while idle and read it back
	task automatic set_data_length(input logic [LEN_W-1:0] value);
		wait_drained();
		apb_access(1'b1, value);
		apb_access(1'b0, '0);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		int             dl_plan[12];
		logic [LEN_W-1:0] dl;
		logic [CW_W-1:0]  data;
		logic           op;
		dl_plan = '{1, 57, 0, 63, 58, 2, 3, 26, 7, 11, 33, 4};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset length of four data bits, seven-bit code
		send_word(OP_ENCODE, '0);
		send_word(OP_ENCODE, ALL_ONES);
		send_word(OP_ENCODE, 63'h7FFF_FFFF_FFFF_FFF5);
		send_word(OP_DECODE, '0);
		send_word(OP_DECODE, ALL_ONES);
		send_word(OP_DECODE, 63'h1);
		send_word(OP_DECODE, 63'h40);
		send_word(OP_DECODE, 63'h7FFF_FFFF_FFFF_FF80);

		// Six-bit code: syndrome seven lies past the code length
		set_data_length(6'd3);
		send_word(OP_DECODE, 63'hC);
		send_word(OP_ENCODE, 63'h7);
		send_word(OP_DECODE, 63'h3F);

		// Zero length acts as one data bit
		set_data_length(6'd0);
		send_word(OP_ENCODE, ALL_ONES);
		send_word(OP_DECODE, 63'h7);

		// Top of the register saturates to the full 63-bit code
		set_data_length(6'd63);
		send_word(OP_ENCODE, ALL_ONES);
		send_word(OP_DECODE, ALL_ONES);
		send_word(OP_DECODE, 63'h4000_0000_0000_0000);
		send_word(OP_ENCODE, '0);

		set_data_length(6'd57);
		send_word(OP_ENCODE, 63'h01FF_FFFF_FFFF_FFFF);
		send_word(OP_DECODE, 63'h2AAA_AAAA_AAAA_AAAA);

		set_data_length(6'd58);
		send_word(OP_ENCODE, 63'h5555_5555_5555_5555);

		// Random: three flow-control regimes, four lengths each
		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					snd_idle = 29;
					rcv_idle = 75;
				end
				1: begin
					snd_idle = 75;
					rcv_idle = 29;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			for (int phase = 0; phase < 4; phase++) begin
				if (regime * 4 + phase >= 10)
					dl = LEN_W'($urandom_range(63));
				else
					dl = LEN_W'(dl_plan[regime * 4 + phase]);
				set_data_length(dl);
				// Stall the result side for a long stretch so the pipeline fills
				if (regime == 2 && phase == 0)
					hold_pending = 1'b1;
				for (int n = 0; n < PHASE_ITEMS; n++) begin
					op = $urandom_range(1);
					data = CW_W'({$urandom, $urandom});
					send_word(op, data);
				end
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("hamming_sec_encode_decode_core_tb: clean");
		else
			$display("hamming_sec_encode_decode_core_tb: errors");
		$finish;
	end

endmodule

// ===== hamming_sec_encode_decode_core.f =====
rtl/hsc_pkg.sv
rtl/hsc_apb_regs.sv
rtl/hsc_place_stage.sv
rtl/hsc_syndrome_stage.sv
rtl/hsc_finish_stage.sv
rtl/hamming_sec_encode_decode_core.sv
dv/hamming_sec_checker.sv
dv/hamming_sec_encode_decode_core_tb.sv
